[rtl/bmu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmu_pkg
// Shared types and codes for the breakpoint match unit.
// ----------------------------------------------------------------------------
package bmu_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ADDR_W  = 16;
    localparam int KIND_W  = 2;
    localparam int CMD_W   = 4;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 5;
    localparam int DEPTH_W = 8;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // commands
    localparam logic [CMD_W-1:0] CMD_CHECK      = 4'd0;
    localparam logic [CMD_W-1:0] CMD_ADD        = 4'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE_ANY = 4'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd4;
    localparam logic [CMD_W-1:0] CMD_CALL       = 4'd5;
    localparam logic [CMD_W-1:0] CMD_RETURN     = 4'd6;
    localparam logic [CMD_W-1:0] CMD_ARM_NEXT   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_ARM_FINISH = 4'd8;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_DUP  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
    localparam logic [STAT_W-1:0] ST_NONE = 2'd3;

    localparam logic [KIND_W-1:0] KIND_EXEC = 2'd0;

    // command token that walks the cell chain, collecting results
    typedef struct packed {
        logic              valid;
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [KIND_W-1:0] kind;
        logic              hit;
        logic              dup;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
        logic [CNT_W-1:0]  count;
    } bmu_token_t;

    // slot write issued once an add has seen the whole table
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [ADDR_W-1:0] wr_addr;
        logic [KIND_W-1:0] wr_kind;
    } bmu_commit_t;

endpackage

[rtl/bmu_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmu_cell
// One breakpoint slot: compares the passing token, updates it, forwards it.
// ----------------------------------------------------------------------------
module bmu_cell
    import bmu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [IDX_W-1:0]    slot_id,
    input  bmu_token_t          tok_in,
    input  bmu_commit_t         commit,
    output bmu_token_t          tok_out
);

    logic [ADDR_W-1:0] addr_reg;
    logic [KIND_W-1:0] kind_reg;
    logic              valid_reg;
    logic              valid_next;
    bmu_token_t        tok_reg;
    bmu_token_t        tok_next;

    logic addr_eq;
    logic match_exact;
    logic match_any;
    logic wr_here;

    assign addr_eq     = valid_reg && (addr_reg == tok_in.addr);
    assign match_exact = addr_eq && (kind_reg == tok_in.kind);
    assign match_any   = addr_eq;
    assign wr_here     = commit.wr_en && (commit.wr_idx == slot_id);

    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        if (tok_in.valid)
        begin
            case (tok_in.cmd)
                CMD_CHECK:
                begin
                    if (match_exact)
                        tok_next.hit = 1'b1;
                end
                CMD_ADD:
                begin
                    if (match_exact)
                        tok_next.dup = 1'b1;
                    if (!valid_reg && !tok_in.free_found)
                    begin
                        tok_next.free_found = 1'b1;
                        tok_next.free_idx   = slot_id;
                    end
                end
                CMD_REMOVE, CMD_REMOVE_ANY:
                begin
                    if ((tok_in.cmd == CMD_REMOVE) ? match_exact : match_any)
                    begin
                        valid_next = 1'b0;
                        if (tok_in.count != COUNT_MAX)
                            tok_next.count = tok_in.count + CNT_W'(1);
                    end
                end
                CMD_CLEAR:
                begin
                    valid_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        if (wr_here)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            addr_reg <= commit.wr_addr;
            kind_reg <= commit.wr_kind;
        end
    end

    assign tok_out = tok_reg;

endmodule

[rtl/breakpoint_match_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breakpoint_match_unit
// Breakpoint/watchpoint table built as a chain of slot cells plus depth trigger.
// ----------------------------------------------------------------------------
// A command taken while idle is registered in each slot cell in turn, and its
// result is then registered at the outputs, with done high for a single cycle.
// A new command is not taken until the last one is out; the token walks one
// slot cell per cycle and busy stays high until the result is out.
// Reset: all slot valid marks, the call depth and the trigger state are cleared.
// The receiver cannot stall; done is a one-cycle strobe.
module breakpoint_match_unit
    import bmu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   command,
    input  logic [ADDR_W-1:0]  bp_addr,
    input  logic [KIND_W-1:0]  access_kind,
    output logic               done,
    output logic               hit,
    output logic [STAT_W-1:0]  status,
    output logic [CNT_W-1:0]   removed_count
);

    logic               busy_reg,   busy_next;
    logic               done_reg,   done_next;
    logic               hit_reg,    hit_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [DEPTH_W-1:0] now_reg,    now_next;
    logic [DEPTH_W-1:0] target_reg, target_next;
    logic               armed_reg,  armed_next;

    logic        accept;
    logic        trig_fire;
    bmu_token_t  tok_head;
    bmu_token_t  tok_last;
    bmu_commit_t commit;
    bmu_token_t  tok_chain [TABLE_ENTRIES];

    assign accept    = start && !busy_reg;
    assign trig_fire = (command == CMD_CHECK) && (access_kind == KIND_EXEC)
                       && armed_reg && (now_reg == target_reg);

    always_comb
    begin
        tok_head       = '0;
        tok_head.valid = accept;
        tok_head.cmd   = command;
        tok_head.addr  = bp_addr;
        tok_head.kind  = access_kind;
        tok_head.hit   = trig_fire;
    end

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            bmu_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .slot_id (IDX_W'(gi)),
                .tok_in  ((gi == 0) ? tok_head : tok_chain[(gi == 0) ? 0 : gi - 1]),
                .commit  (commit),
                .tok_out (tok_chain[gi])
            );
        end
    endgenerate

    assign tok_last = tok_chain[TABLE_ENTRIES-1];

    always_comb
    begin
        commit.wr_en   = tok_last.valid && (tok_last.cmd == CMD_ADD)
                         && !tok_last.dup && tok_last.free_found;
        commit.wr_idx  = tok_last.free_idx;
        commit.wr_addr = tok_last.addr;
        commit.wr_kind = tok_last.kind;
    end

    // depth tracking and result formation
    always_comb
    begin
        now_next    = now_reg;
        target_next = target_reg;
        armed_next  = armed_reg;
        if (accept)
        begin
            case (command)
                CMD_CHECK:
                begin
                    if (trig_fire)
                        armed_next = 1'b0;
                end
                CMD_CALL:       now_next = now_reg + DEPTH_W'(1);
                CMD_RETURN:     now_next = now_reg - DEPTH_W'(1);
                CMD_ARM_NEXT:
                begin
                    target_next = now_reg;
                    armed_next  = 1'b1;
                end
                CMD_ARM_FINISH:
                begin
                    target_next = now_reg - DEPTH_W'(1);
                    armed_next  = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        busy_next   = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (tok_last.valid)
            busy_next = 1'b0;

        done_next   = tok_last.valid;
        hit_next    = 1'b0;
        status_next = ST_OK;
        count_next  = '0;
        case (tok_last.cmd)
            CMD_CHECK:
                hit_next = tok_last.hit;
            CMD_ADD:
            begin
                if (tok_last.dup)
                    status_next = ST_DUP;
                else if (!tok_last.free_found)
                    status_next = ST_FULL;
            end
            CMD_REMOVE, CMD_REMOVE_ANY:
            begin
                count_next = tok_last.count;
                if (tok_last.count == '0)
                    status_next = ST_NONE;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            status_reg <= ST_OK;
            count_reg  <= '0;
            now_reg    <= '0;
            target_reg <= '0;
            armed_reg  <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            now_reg    <= now_next;
            target_reg <= target_next;
            armed_reg  <= armed_next;
            if (tok_last.valid)
            begin
                hit_reg    <= hit_next;
                status_reg <= status_next;
                count_reg  <= count_next;
            end
        end
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign hit           = hit_reg;
    assign status        = status_reg;
    assign removed_count = count_reg;

endmodule

[rtl/bmu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmu_checker
// Port-level checks for the breakpoint match unit, bound to the top level.
// ----------------------------------------------------------------------------
module bmu_port_checks
    import bmu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               done,
    input  logic               hit,
    input  logic [STAT_W-1:0]  status,
    input  logic [CNT_W-1:0]   removed_count
);

    // a taken command keeps the unit busy until its result
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after transfer");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // only checks report a hit, only removes report a count
    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (status == ST_OK && removed_count == '0))
        else $error("hit with non-ok status or count");

    a_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && removed_count != '0) |-> (status == ST_OK && !hit))
        else $error("removal count with bad status");

endmodule

bind breakpoint_match_unit bmu_port_checks u_bmu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .hit           (hit),
    .status        (status),
    .removed_count (removed_count)
);
